// ----- hw/rtl/fms_pkg.sv -----
// ----------------------------------------------------------------------------
// fms_pkg
// Shared codes, constants and helpers of the fuzzy membership standardizer.
// ----------------------------------------------------------------------------
package fms_pkg;

  // Fraction bits of the internal ratio, width and fraction bits of the J-shape denominator
  localparam int unsigned RatioBits = 30;
  localparam int unsigned DenBits   = 61;
  localparam int unsigned JOneShift = 44;

  typedef enum logic [2:0] {
    MODE_SIG_INC = 3'd0,
    MODE_SIG_DEC = 3'd1,
    MODE_J_INC   = 3'd2,
    MODE_J_DEC   = 3'd3,
    MODE_LIN_INC = 3'd4,
    MODE_LIN_DEC = 3'd5
  } fm_mode_e;

  typedef enum logic [2:0] {
    REG_FUNC_MODE     = 3'd0,
    REG_POINT_LOW     = 3'd1,
    REG_POINT_HIGH    = 3'd2,
    REG_NODATA_VALUE  = 3'd3,
    REG_NODATA_ENABLE = 3'd4
  } reg_idx_e;

  // How the membership of one beat is finished at the end of the pipe
  typedef enum logic [1:0] {
    KIND_CONST = 2'd0,
    KIND_COS   = 2'd1,
    KIND_J     = 2'd2,
    KIND_LIN   = 2'd3
  } kind_e;

  // Round a Q1.30 value half up to fb fraction bits, capped at 1.0
  function automatic logic [31:0] round_q30(input logic [30:0] v, input int unsigned fb);
    logic [31:0] r;
    r = ({1'b0, v} + (32'd1 << (29 - fb))) >> (30 - fb);
    if (r > (32'd1 << fb)) begin
      r = 32'd1 << fb;
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/fms_if.sv -----
// ----------------------------------------------------------------------------
// fms_if
// Valid/ready stream channels for samples and membership results.
// ----------------------------------------------------------------------------
interface fms_in_if #(
  parameter int unsigned SAMPLE_WIDTH = 32
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface fms_out_if #(
  parameter int unsigned FRAC_BITS = 16
);
  logic               valid;
  logic               ready;
  logic [FRAC_BITS:0] membership;
  logic               is_nodata;
  logic               setup_error;

  modport source (output valid, output membership, output is_nodata, output setup_error,
                  input ready);
  modport sink   (input valid, input membership, input is_nodata, input setup_error,
                  output ready);
endinterface

// ----- hw/rtl/fms_div_cell.sv -----
// ----------------------------------------------------------------------------
// fms_div_cell
// One restoring division step: shift remainder, subtract divisor when it fits,
// append one quotient bit and pass everything to the next cell.
// ----------------------------------------------------------------------------
module fms_div_cell #(
  parameter int unsigned DW  = 40,
  parameter int unsigned QW  = 30,
  parameter int unsigned SBW = 8
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           vld_i,
  input  logic [DW-1:0]  rem_i,
  input  logic [DW-1:0]  dvs_i,
  input  logic [QW-1:0]  q_i,
  input  logic [SBW-1:0] sb_i,
  output logic           vld_o,
  output logic [DW-1:0]  rem_o,
  output logic [DW-1:0]  dvs_o,
  output logic [QW-1:0]  q_o,
  output logic [SBW-1:0] sb_o
);

  logic [DW:0]    rem2;
  logic [DW:0]    diff;
  logic           fits;
  logic           vld_q;
  logic [DW-1:0]  rem_q, rem_d;
  logic [DW-1:0]  dvs_q;
  logic [QW-1:0]  q_q, q_d;
  logic [SBW-1:0] sb_q;

  always_comb begin
    rem2  = {rem_i, 1'b0};
    diff  = rem2 - {1'b0, dvs_i};
    fits  = rem2 >= {1'b0, dvs_i};
    rem_d = fits ? diff[DW-1:0] : rem2[DW-1:0];
    q_d   = {q_i[QW-2:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= rem_d;
      dvs_q <= dvs_i;
      q_q   <= q_d;
      sb_q  <= sb_i;
    end
  end

  assign vld_o = vld_q;
  assign rem_o = rem_q;
  assign dvs_o = dvs_q;
  assign q_o   = q_q;
  assign sb_o  = sb_q;

endmodule

// ----- hw/rtl/fms_cos_rom.sv -----
// ----------------------------------------------------------------------------
// fms_cos_rom
// Cos-squared table over a quarter period with linear interpolation; the two
// table reads are registered, interpolation and rounding follow.
// ----------------------------------------------------------------------------
module fms_cos_rom
  import fms_pkg::*;
#(
  parameter int unsigned COS_TABLE_BITS = 10,
  parameter int unsigned FRAC_BITS      = 16
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic [RatioBits-1:0] t_i,
  output logic [FRAC_BITS:0]   res_o
);

  localparam int unsigned RomLen  = (1 << COS_TABLE_BITS) + 1;
  localparam int unsigned Sh      = RatioBits - COS_TABLE_BITS;
  localparam longint unsigned HalfPi = 64'd1686629713;
  localparam longint unsigned QOne   = 64'd1 << 30;

  // Entries run up to 1.0, so they carry one integer bit
  typedef logic [RatioBits:0] rom_t [RomLen];

  // Shift-and-subtract quotient, evaluated only while the table is built
  function automatic longint unsigned udiv(input longint unsigned num,
                                           input longint unsigned den);
    longint unsigned q;
    longint unsigned rem;
    q   = '0;
    rem = '0;
    for (int k = 63; k >= 0; k--) begin
      rem = {rem[62:0], num[k]};
      if (rem >= den) begin
        rem  = rem - den;
        q[k] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic rom_t build_rom();
    rom_t            rom;
    longint unsigned th, x2, mag, c;
    longint          sum;
    for (int i = 0; i < RomLen; i++) begin
      th  = (longint'(i) * HalfPi) >> COS_TABLE_BITS;
      x2  = (th * th) >> 30;
      mag = QOne;
      sum = longint'(QOne);
      for (int n = 1; n <= 10; n++) begin
        mag = udiv((mag * x2) >> 30, 64'((2 * n - 1) * (2 * n)));
        if (n[0]) begin
          sum = sum - longint'(mag);
        end else begin
          sum = sum + longint'(mag);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      c = longint'(sum);
      if (c > QOne) begin
        c = QOne;
      end
      c = (c * c + (QOne >> 1)) >> 30;
      if (c > QOne) begin
        c = QOne;
      end
      rom[i] = c[RatioBits:0];
    end
    return rom;
  endfunction

  localparam rom_t CosRom = build_rom();

  logic [COS_TABLE_BITS-1:0] idx;
  logic [COS_TABLE_BITS:0]   idx_nx;
  logic [RatioBits:0]        y0_q, y1_q;
  logic [Sh-1:0]             fr_q;
  logic [RatioBits:0]        gap;
  logic [RatioBits+Sh:0]     prod;
  logic [RatioBits:0]        step;
  logic [RatioBits:0]        val;
  logic [31:0]               rnd;

  assign idx    = t_i[RatioBits-1:Sh];
  assign idx_nx = {1'b0, idx} + 1'b1;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      y0_q <= CosRom[{1'b0, idx}];
      y1_q <= CosRom[idx_nx];
      fr_q <= t_i[Sh-1:0];
    end
  end

  always_comb begin
    gap  = (y0_q >= y1_q) ? (y0_q - y1_q) : (y1_q - y0_q);
    prod = gap * fr_q;
    step = prod[RatioBits+Sh:Sh];
    val  = (y0_q >= y1_q) ? (y0_q - step) : (y0_q + step);
    rnd  = round_q30(val, FRAC_BITS);
  end

  assign res_o = rnd[FRAC_BITS:0];

endmodule

// ----- hw/rtl/fuzzy_membership_standardizer.sv -----
// Throughput: one sample per cycle; the whole pipe advances together, held
// only while a result beat waits on the output register.
// The ratio comes from a 30-cell restoring divider chain, the J shape from a
// second chain of FRAC_BITS+1 cells after a 30x30 multiplier.
// Reset clears the valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
// fuzzy_membership_standardizer
// Sigmoidal, J-shaped and linear fuzzy membership of raster samples, Q1.16.
// ----------------------------------------------------------------------------
module fuzzy_membership_standardizer
  import fms_pkg::*;
#(
  parameter int unsigned SAMPLE_WIDTH   = 32,
  parameter int unsigned FRAC_BITS      = 16,
  parameter int unsigned COS_TABLE_BITS = 10
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [2:0]              cfg_idx_i,
  input  logic [SAMPLE_WIDTH-1:0] cfg_wdata_i,
  fms_in_if.sink                  smp_i,
  fms_out_if.source               mbr_o
);

  localparam int unsigned SW  = SAMPLE_WIDTH;
  localparam int unsigned D1W = SW + 8;
  localparam int unsigned NJ  = FRAC_BITS + 1;
  localparam int unsigned QJW = FRAC_BITS + 2;

  typedef struct packed {
    kind_e              kind;
    logic               sat;
    logic [FRAC_BITS:0] val;
    logic               nod;
    logic               err;
  } sb_t;

  localparam int unsigned SBW = $bits(sb_t);
  localparam logic [FRAC_BITS:0] One = (FRAC_BITS + 1)'(1) << FRAC_BITS;

  // ---------------- configuration ----------------
  logic [2:0]    mode_q;
  logic [SW-1:0] plo_q, phi_q, ndv_q;
  logic          nde_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_SIG_INC;
      plo_q  <= '0;
      phi_q  <= SW'(1);
      ndv_q  <= '0;
      nde_q  <= 1'b0;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_FUNC_MODE:     mode_q <= cfg_wdata_i[2:0];
        REG_POINT_LOW:     plo_q  <= cfg_wdata_i;
        REG_POINT_HIGH:    phi_q  <= cfg_wdata_i;
        REG_NODATA_VALUE:  ndv_q  <= cfg_wdata_i;
        REG_NODATA_ENABLE: nde_q  <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // ---------------- pipeline advance ----------------
  logic en;
  logic out_vld_q;

  assign en          = !out_vld_q || mbr_o.ready;
  assign smp_i.ready = en;

  // ---------------- front: classify the sample ----------------
  logic signed [SW:0] x_e, a_e, b_e, dxa, dbx, span;
  logic [SW-1:0]      d, span_u;
  logic               err, nod, x_le_a, x_ge_b, use_dbx, sat;
  sb_t                sb_f;

  always_comb begin
    x_e     = {smp_i.sample[SW-1], smp_i.sample};
    a_e     = {plo_q[SW-1], plo_q};
    b_e     = {phi_q[SW-1], phi_q};
    dxa     = x_e - a_e;
    dbx     = b_e - x_e;
    span    = b_e - a_e;
    span_u  = span[SW-1:0];
    err     = a_e >= b_e;
    nod     = nde_q && (smp_i.sample == ndv_q);
    x_le_a  = x_e <= a_e;
    x_ge_b  = x_e >= b_e;
    use_dbx = 1'b0;
    sb_f    = '{kind: KIND_CONST, sat: 1'b0, val: '0, nod: 1'b0, err: 1'b0};
    case (fm_mode_e'(mode_q))
      MODE_SIG_INC: begin
        if (x_le_a)      sb_f.val = '0;
        else if (x_ge_b) sb_f.val = One;
        else begin
          sb_f.kind = KIND_COS;
          use_dbx   = 1'b1;
        end
      end
      MODE_SIG_DEC: begin
        if (x_le_a)      sb_f.val = One;
        else if (x_ge_b) sb_f.val = '0;
        else             sb_f.kind = KIND_COS;
      end
      MODE_J_INC: begin
        if (x_ge_b) sb_f.val = One;
        else begin
          sb_f.kind = KIND_J;
          use_dbx   = 1'b1;
        end
      end
      MODE_J_DEC: begin
        if (x_le_a) sb_f.val = One;
        else        sb_f.kind = KIND_J;
      end
      MODE_LIN_INC: begin
        if (x_le_a)      sb_f.val = '0;
        else if (x_ge_b) sb_f.val = One;
        else             sb_f.kind = KIND_LIN;
      end
      MODE_LIN_DEC: begin
        if (x_le_a)      sb_f.val = One;
        else if (x_ge_b) sb_f.val = '0;
        else begin
          sb_f.kind = KIND_LIN;
          use_dbx   = 1'b1;
        end
      end
      default: sb_f.val = '0;
    endcase
    d        = use_dbx ? dbx[SW-1:0] : dxa[SW-1:0];
    sat      = {8'b0, d} >= {span_u, 8'b0};
    sb_f.sat = (sb_f.kind == KIND_J) && sat;
    // setup error wins over nodata, both force a constant zero
    if (err) begin
      sb_f = '{kind: KIND_CONST, sat: 1'b0, val: '0, nod: 1'b0, err: 1'b1};
    end else if (nod) begin
      sb_f = '{kind: KIND_CONST, sat: 1'b0, val: '0, nod: 1'b1, err: 1'b0};
    end
  end

  // ---------------- ratio divider chain ----------------
  logic                 c1_vld [RatioBits+1];
  logic [D1W-1:0]       c1_rem [RatioBits+1];
  logic [D1W-1:0]       c1_dvs [RatioBits+1];
  logic [RatioBits-1:0] c1_q   [RatioBits+1];
  logic [SBW-1:0]       c1_sb  [RatioBits+1];

  logic s0_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q <= 1'b0;
    end else if (en) begin
      s0_vld_q <= smp_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c1_sb[0]  <= sb_f;
      c1_dvs[0] <= (sb_f.kind == KIND_J) ? {span_u, 8'b0} : {8'b0, span_u};
      c1_rem[0] <= ((sb_f.kind == KIND_CONST) || sb_f.sat) ? '0 : {8'b0, d};
      c1_q[0]   <= '0;
    end
  end

  assign c1_vld[0] = s0_vld_q;

  for (genvar i = 0; i < RatioBits; i++) begin : g_ratio
    fms_div_cell #(.DW(D1W), .QW(RatioBits), .SBW(SBW)) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .en_i  (en),
      .vld_i (c1_vld[i]),
      .rem_i (c1_rem[i]),
      .dvs_i (c1_dvs[i]),
      .q_i   (c1_q[i]),
      .sb_i  (c1_sb[i]),
      .vld_o (c1_vld[i+1]),
      .rem_o (c1_rem[i+1]),
      .dvs_o (c1_dvs[i+1]),
      .q_o   (c1_q[i+1]),
      .sb_o  (c1_sb[i+1])
    );
  end

  // ---------------- square, table read, linear rounding ----------------
  sb_t                  sb1, m_sb_q, sb_m;
  logic [RatioBits-1:0] r;
  logic [31:0]          lin_rnd;
  logic [59:0]          m_r2_q;
  logic                 m_rz_q, m_vld_q;
  logic [FRAC_BITS:0]   cos_res;

  always_comb begin
    sb1     = sb_t'(c1_sb[RatioBits]);
    r       = sb1.sat ? {RatioBits{1'b1}} : c1_q[RatioBits];
    lin_rnd = round_q30({1'b0, c1_q[RatioBits]}, FRAC_BITS);
    sb_m    = sb1;
    if (sb1.kind == KIND_LIN) begin
      sb_m.val = lin_rnd[FRAC_BITS:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_vld_q <= 1'b0;
    end else if (en) begin
      m_vld_q <= c1_vld[RatioBits];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_r2_q <= r * r;
      m_rz_q <= r == '0;
      m_sb_q <= sb_m;
    end
  end

  fms_cos_rom #(.COS_TABLE_BITS(COS_TABLE_BITS), .FRAC_BITS(FRAC_BITS)) u_cos (
    .clk_i(clk_i),
    .en_i (en),
    .t_i  (c1_q[RatioBits]),
    .res_o(cos_res)
  );

  // ---------------- J-shape divider chain ----------------
  logic               c2_vld [NJ+1];
  logic [DenBits-1:0] c2_rem [NJ+1];
  logic [DenBits-1:0] c2_dvs [NJ+1];
  logic [QJW-1:0]     c2_q   [NJ+1];
  logic [SBW-1:0]     c2_sb  [NJ+1];
  sb_t                sb_n;
  logic               n_vld_q;

  always_comb begin
    sb_n = m_sb_q;
    if (m_sb_q.kind == KIND_COS) begin
      sb_n.val = cos_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_vld_q <= 1'b0;
    end else if (en) begin
      n_vld_q <= m_vld_q;
    end
  end

  // 1/(1+r^2) with 1+r^2 in Q17.44: the integer quotient bit is set only for r of zero
  always_ff @(posedge clk_i) begin
    if (en) begin
      c2_sb[0]  <= sb_n;
      c2_dvs[0] <= (DenBits'(1) << JOneShift) + DenBits'(m_r2_q);
      c2_rem[0] <= m_rz_q ? '0 : (DenBits'(1) << JOneShift);
      c2_q[0]   <= QJW'(m_rz_q);
    end
  end

  assign c2_vld[0] = n_vld_q;

  for (genvar j = 0; j < NJ; j++) begin : g_jdiv
    fms_div_cell #(.DW(DenBits), .QW(QJW), .SBW(SBW)) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .en_i  (en),
      .vld_i (c2_vld[j]),
      .rem_i (c2_rem[j]),
      .dvs_i (c2_dvs[j]),
      .q_i   (c2_q[j]),
      .sb_i  (c2_sb[j]),
      .vld_o (c2_vld[j+1]),
      .rem_o (c2_rem[j+1]),
      .dvs_o (c2_dvs[j+1]),
      .q_o   (c2_q[j+1]),
      .sb_o  (c2_sb[j+1])
    );
  end

  // ---------------- finish and output register ----------------
  sb_t                sb2;
  logic [QJW:0]       j_half;
  logic [FRAC_BITS:0] j_val, fin_val;
  logic [FRAC_BITS:0] out_mbr_q;
  logic               out_nod_q, out_err_q;

  always_comb begin
    sb2    = sb_t'(c2_sb[NJ]);
    j_half = ({1'b0, c2_q[NJ]} + 1'b1) >> 1;
    j_val  = (j_half > (QJW + 1)'(One)) ? One : j_half[FRAC_BITS:0];
    fin_val = (sb2.kind == KIND_J) ? j_val : sb2.val;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= c2_vld[NJ];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_mbr_q <= fin_val;
      out_nod_q <= sb2.nod;
      out_err_q <= sb2.err;
    end
  end

  assign mbr_o.valid       = out_vld_q;
  assign mbr_o.membership  = out_mbr_q;
  assign mbr_o.is_nodata   = out_nod_q;
  assign mbr_o.setup_error = out_err_q;

  // ---------------- assertions ----------------
  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> !(out_nod_q && out_err_q))
    else $error("nodata and setup error flagged on one beat");

  a_flag_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && (out_nod_q || out_err_q)) |-> (out_mbr_q == '0))
    else $error("flagged beat carries nonzero membership");

  a_mbr_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (out_mbr_q <= One))
    else $error("membership above one");

  a_tail_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && c2_vld[NJ]) |=> out_vld_q)
    else $error("finished beat lost at the output register");

endmodule
